FILE: hw/rtl/fbsc_pkg.sv
// Shared types and constants for the FAT boot sector classifier.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fbsc_pkg;

  // Byte position counter and the capture window.
  localparam int POS_W                = 13;
  localparam int DEF_MAX_SECTOR_BYTES = 4096;
  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] CAP_LIMIT = POS_W'(DEF_MAX_SECTOR_BYTES);

  // Header queue between the capture front and the compute back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Root directory divide: numerator is entries * 32 + bps - 1.
  localparam int QUO_W  = 22;
  localparam int STEP_W = $clog2(QUO_W);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLUSTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT12_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT16_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT32_LIMIT   = 3'd4;

  // Configuration reset values.
  localparam logic [12:0] RST_SECTOR_SIZE = 13'd512;
  localparam logic [20:0] RST_MAX_CLUSTER = 21'd32768;
  localparam logic [31:0] RST_FAT12_LIMIT = 32'd4084;
  localparam logic [31:0] RST_FAT16_LIMIT = 32'd65524;
  localparam logic [31:0] RST_FAT32_LIMIT = 32'd268435445;

  // Boot record constants.
  localparam logic [7:0]  JMP_SHORT  = 8'hEB;
  localparam logic [7:0]  JMP_NOP    = 8'h90;
  localparam logic [7:0]  JMP_NEAR   = 8'hE9;
  localparam logic [15:0] BOOT_SIG   = 16'h55AA;

  // File system type codes.
  localparam logic [1:0] FS_INVALID = 2'd0;
  localparam logic [1:0] FS_FAT12   = 2'd1;
  localparam logic [1:0] FS_FAT16   = 2'd2;
  localparam logic [1:0] FS_FAT32   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  fs_type;
    logic [31:0] cluster_count;
  } out_item_t;

  typedef struct packed {
    logic [12:0] sector_size;
    logic [20:0] max_cluster_bytes;
    logic [31:0] fat12_cluster_limit;
    logic [31:0] fat16_cluster_limit;
    logic [31:0] fat32_cluster_limit;
  } cfg_t;

  // Captured boot record fields of one sector.
  typedef struct packed {
    logic [15:0] jump_bytes;
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] small_total;
    logic [15:0] small_fat_size;
    logic [31:0] large_total;
    logic [31:0] large_fat_size;
    logic [15:0] signature_bytes;
  } hdr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fbsc_front.sv
// Capture front: takes sector bytes one per transfer and collects the
// boot record fields; pushes the finished header at the last byte. Uses fbsc_pkg.
`default_nettype none

module fbsc_front #(
  parameter int MAX_SECTOR_BYTES = fbsc_pkg::DEF_MAX_SECTOR_BYTES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire fbsc_pkg::in_item_t in_data,
  output logic                  q_push,
  output fbsc_pkg::hdr_t        q_push_data,
  input  wire logic             q_full
);
  import fbsc_pkg::*;

  // Bytes at this offset and beyond are not captured.
  localparam logic [POS_W-1:0] CAP_END = POS_W'(MAX_SECTOR_BYTES);

  logic [POS_W-1:0] pos;
  hdr_t             cur;
  hdr_t             cur_next;
  logic             accept;
  logic [7:0]       b;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;

  // Merge the incoming byte into the field that owns its offset.
  always_comb begin
    cur_next = cur;
    if (pos < CAP_END) begin
      unique case (pos)
        13'd0:   cur_next.jump_bytes[15:8]          = b;
        13'd2:   cur_next.jump_bytes[7:0]           = b;
        13'd11:  cur_next.bytes_per_sector[7:0]     = b;
        13'd12:  cur_next.bytes_per_sector[15:8]    = b;
        13'd13:  cur_next.sectors_per_cluster       = b;
        13'd14:  cur_next.reserved_sectors[7:0]     = b;
        13'd15:  cur_next.reserved_sectors[15:8]    = b;
        13'd16:  cur_next.fat_copies                = b;
        13'd17:  cur_next.root_entries[7:0]         = b;
        13'd18:  cur_next.root_entries[15:8]        = b;
        13'd19:  cur_next.small_total[7:0]          = b;
        13'd20:  cur_next.small_total[15:8]         = b;
        13'd22:  cur_next.small_fat_size[7:0]       = b;
        13'd23:  cur_next.small_fat_size[15:8]      = b;
        13'd32:  cur_next.large_total[7:0]          = b;
        13'd33:  cur_next.large_total[15:8]         = b;
        13'd34:  cur_next.large_total[23:16]        = b;
        13'd35:  cur_next.large_total[31:24]        = b;
        13'd36:  cur_next.large_fat_size[7:0]       = b;
        13'd37:  cur_next.large_fat_size[15:8]      = b;
        13'd38:  cur_next.large_fat_size[23:16]     = b;
        13'd39:  cur_next.large_fat_size[31:24]     = b;
        13'd510: cur_next.signature_bytes[15:8]     = b;
        13'd511: cur_next.signature_bytes[7:0]      = b;
        default: ;
      endcase
    end
  end

  // The header including the last byte goes to the queue.
  assign q_push      = accept && in_data.last_byte;
  assign q_push_data = cur_next;

  // Position and field registers; both clear after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cur <= '0;
    end else if (accept) begin
      if (in_data.last_byte) begin
        pos <= '0;
        cur <= '0;
      end else begin
        cur <= cur_next;
        if (pos != POS_MAX) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fbsc_queue.sv
// Short header queue between the capture front and the compute back.
// Register based, QUEUE_DEPTH entries; uses fbsc_pkg.
`default_nettype none

module fbsc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fbsc_pkg::hdr_t push_data,
  output logic                full,
  input  wire logic           pop,
  output fbsc_pkg::hdr_t      head,
  output logic                empty
);
  import fbsc_pkg::*;

  hdr_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Storage needs no reset; only the pointers and count do.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fbsc_back.sv
// Compute back: checks a queued header, divides out the root directory
// sectors bit by bit, derives the cluster count and classifies. Uses fbsc_pkg.
`default_nettype none

module fbsc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fbsc_pkg::cfg_t  cfg,
  input  wire logic            q_empty,
  input  wire fbsc_pkg::hdr_t  q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output fbsc_pkg::out_item_t  out_data
);
  import fbsc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_SUB   = 3'd4;
  localparam logic [2:0] S_CLASS = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state;
  hdr_t              h;
  logic [31:0]       prod;
  logic [31:0]       tot;
  logic [2:0]        shamt;
  logic [15:0]       rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic [31:0]       sum;
  logic [31:0]       count;
  logic [1:0]        res_type;
  logic [31:0]       res_count;

  // Header check terms.
  logic        jump_ok;
  logic        spc_pow2;
  logic [23:0] clus_bytes;
  logic        hdr_ok;
  logic [31:0] fsz_sel;
  logic [31:0] fat_prod;
  logic [QUO_W-1:0] num;

  // Divider step terms.
  logic [16:0] rem_sh;
  logic        fits;
  logic [16:0] rem_sub;

  logic        out_free;

  function automatic logic [2:0] spc_log2(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // Header checks and the operands prepared in the check step.
  always_comb begin
    jump_ok = ((h.jump_bytes[15:8] == JMP_SHORT) && (h.jump_bytes[7:0] == JMP_NOP)) ||
              (h.jump_bytes[15:8] == JMP_NEAR);
    spc_pow2   = (h.sectors_per_cluster != '0) &&
                 ((h.sectors_per_cluster & (h.sectors_per_cluster - 8'd1)) == '0);
    clus_bytes = {8'd0, h.bytes_per_sector} * {16'd0, h.sectors_per_cluster};
    hdr_ok     = jump_ok &&
                 (h.bytes_per_sector == {3'b000, cfg.sector_size}) &&
                 (h.bytes_per_sector != '0) &&
                 spc_pow2 &&
                 (clus_bytes <= {3'b000, cfg.max_cluster_bytes}) &&
                 (h.reserved_sectors != '0) &&
                 (h.signature_bytes == BOOT_SIG);
    fsz_sel    = (h.small_fat_size != '0) ? {16'd0, h.small_fat_size} : h.large_fat_size;
    fat_prod   = {24'd0, h.fat_copies} * fsz_sel;
    num        = {1'b0, h.root_entries, 5'b00000} +
                 {6'd0, h.bytes_per_sector} - QUO_W'(1);
  end

  // One restoring divide step: root = num / bps.
  always_comb begin
    rem_sh  = {rem, quo[QUO_W-1]};
    fits    = (rem_sh >= {1'b0, h.bytes_per_sector});
    rem_sub = rem_sh - {1'b0, h.bytes_per_sector};
  end

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            h     <= q_head;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          prod  <= fat_prod;
          tot   <= (h.small_total != '0) ? {16'd0, h.small_total} : h.large_total;
          shamt <= spc_log2(h.sectors_per_cluster);
          rem   <= '0;
          quo   <= num;
          step  <= STEP_W'(QUO_W - 1);
          if (hdr_ok) begin
            state <= S_DIV;
          end else begin
            res_type  <= FS_INVALID;
            res_count <= '0;
            state     <= S_DONE;
          end
        end
        S_DIV: begin
          rem <= fits ? rem_sub[15:0] : rem_sh[15:0];
          quo <= {quo[QUO_W-2:0], fits};
          if (step == '0) begin
            state <= S_ADD;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_ADD: begin
          sum   <= {16'd0, h.reserved_sectors} + prod + {{(32-QUO_W){1'b0}}, quo};
          state <= S_SUB;
        end
        S_SUB: begin
          count <= (tot - sum) >> shamt;
          state <= S_CLASS;
        end
        S_CLASS: begin
          res_count <= count;
          if (count <= cfg.fat12_cluster_limit) begin
            res_type <= FS_FAT12;
          end else if (count <= cfg.fat16_cluster_limit) begin
            res_type <= FS_FAT16;
          end else if (count <= cfg.fat32_cluster_limit) begin
            res_type <= FS_FAT32;
          end else begin
            res_type <= FS_INVALID;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: loads when the result is done and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_data.fs_type       <= res_type;
      out_data.cluster_count <= res_count;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fat_boot_sector_classifier.sv
// FAT boot sector classifier, top level: configuration registers, capture
// front, header queue and compute back. Uses fbsc_pkg and the fbsc_* modules.
//
// Usage: the bytes of a partition's first sector enter on the input channel
// (in_valid / in_ready / in_data), one byte per transfer from offset 0, with
// last_byte set on the final byte. Each sector gives one result on the output
// channel (out_valid / out_ready / out_data): the FAT type and cluster count.
// Bytes are taken at one per cycle. After the last byte is transferred, a
// valid header passes through the check, the 22-step bit-serial root
// directory divide and the add, subtract and classify steps; a header that
// fails the check goes straight to the result, which waits for a free output.
// A two-entry header queue lets the next sector stream in meanwhile; the
// input stalls only when that queue is full. A stalled receiver holds the
// result in the output register and the back waits, then the queue fills.
// Configuration writes (cfg_we / cfg_index / cfg_wdata) take effect at once
// and belong in idle periods; unknown indexes are ignored. Synchronous reset
// restores the default configuration, clears the capture front's fields and empties the header queue.
`default_nettype none

module fat_boot_sector_classifier #(
  parameter int MAX_SECTOR_BYTES = fbsc_pkg::DEF_MAX_SECTOR_BYTES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire fbsc_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output fbsc_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [fbsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fbsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fbsc_pkg::*;

  cfg_t cfg;
  logic q_push;
  hdr_t q_push_data;
  logic q_full;
  logic q_pop;
  hdr_t q_head;
  logic q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sector_size         <= RST_SECTOR_SIZE;
      cfg.max_cluster_bytes   <= RST_MAX_CLUSTER;
      cfg.fat12_cluster_limit <= RST_FAT12_LIMIT;
      cfg.fat16_cluster_limit <= RST_FAT16_LIMIT;
      cfg.fat32_cluster_limit <= RST_FAT32_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECTOR_SIZE: cfg.sector_size         <= cfg_wdata[12:0];
        CFG_MAX_CLUSTER: cfg.max_cluster_bytes   <= cfg_wdata[20:0];
        CFG_FAT12_LIMIT: cfg.fat12_cluster_limit <= cfg_wdata;
        CFG_FAT16_LIMIT: cfg.fat16_cluster_limit <= cfg_wdata;
        CFG_FAT32_LIMIT: cfg.fat32_cluster_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Byte capture.
  fbsc_front #(
    .MAX_SECTOR_BYTES (MAX_SECTOR_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .q_full      (q_full)
  );

  // Header queue.
  fbsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Checks, divide and classification.
  fbsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: bench/fat_type_checker.sv
// Checker for the FAT boot sector classifier: watches both channels and the
// register port, predicts each volume result and compares it on arrival.
// Depends on fbsc_pkg for the payload types, register indexes and constants.
module fat_type_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  fbsc_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  fbsc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [fbsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              results_pending,
  output int                              results_checked
);
  import fbsc_pkg::*;

  // Shadow copy of the configuration registers.
  logic [12:0] sector_size_reg;
  logic [20:0] max_cluster_reg;
  logic [31:0] fat12_limit;
  logic [31:0] fat16_limit;
  logic [31:0] fat32_limit;

  // Boot record fields captured from the sector being streamed.
  logic [POS_W-1:0] byte_pos;
  hdr_t             boot_hdr;

  // Volume results still to come out of the block, oldest first.
  out_item_t expected_volumes[$];

  // Validate the captured header, then derive the cluster count and FAT type.
  function automatic out_item_t classify_volume(hdr_t h);
    logic [31:0] bps;
    logic [31:0] spc;
    logic [31:0] root_sectors;
    logic [31:0] fat_size;
    logic [31:0] total;
    logic [31:0] data_sectors;
    logic [31:0] clusters;
    logic        jump_ok;
    logic        header_ok;
    out_item_t   vol;
    bps = {16'b0, h.bytes_per_sector};
    spc = {24'b0, h.sectors_per_cluster};
    jump_ok = (h.jump_bytes[15:8] == JMP_SHORT && h.jump_bytes[7:0] == JMP_NOP) ||
              h.jump_bytes[15:8] == JMP_NEAR;
    header_ok = jump_ok && bps == {19'b0, sector_size_reg} && bps != 0 &&
                spc != 0 && (spc & (spc - 1)) == 0 &&
                bps * spc <= {11'b0, max_cluster_reg} &&
                h.reserved_sectors != 0 && h.signature_bytes == BOOT_SIG;
    vol.fs_type = FS_INVALID;
    vol.cluster_count = '0;
    if (header_ok) begin
      root_sectors = ({16'b0, h.root_entries} * 32 + (bps - 1)) / bps;
      fat_size = (h.small_fat_size != 0) ? {16'b0, h.small_fat_size} : h.large_fat_size;
      total = (h.small_total != 0) ? {16'b0, h.small_total} : h.large_total;
      data_sectors = total - ({16'b0, h.reserved_sectors} +
                              {24'b0, h.fat_copies} * fat_size + root_sectors);
      clusters = data_sectors / spc;
      vol.cluster_count = clusters;
      // Counts above the FAT32 limit stay invalid but keep their count.
      if (clusters <= fat12_limit) begin
        vol.fs_type = FS_FAT12;
      end else if (clusters <= fat16_limit) begin
        vol.fs_type = FS_FAT16;
      end else if (clusters <= fat32_limit) begin
        vol.fs_type = FS_FAT32;
      end
    end
    return vol;
  endfunction

  // Track register writes, byte transfers and result transfers.
  always @(posedge clk) begin
    out_item_t  want;
    logic [7:0] b;
    if (rst) begin
      sector_size_reg = RST_SECTOR_SIZE;
      max_cluster_reg = RST_MAX_CLUSTER;
      fat12_limit = RST_FAT12_LIMIT;
      fat16_limit = RST_FAT16_LIMIT;
      fat32_limit = RST_FAT32_LIMIT;
      byte_pos = '0;
      boot_hdr = '0;
      expected_volumes.delete();
      mismatch_count = 0;
      results_checked = 0;
      results_pending = 0;
    end else begin
      // Compare each result transfer with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_volumes.size() == 0) begin
          $error("unexpected result: fs_type %0d, cluster_count %0d",
                 out_data.fs_type, out_data.cluster_count);
          mismatch_count++;
        end else begin
          want = expected_volumes.pop_front();
          results_checked++;
          if (out_data.fs_type !== want.fs_type) begin
            $error("fs_type: expected %0d, actual %0d", want.fs_type, out_data.fs_type);
            mismatch_count++;
          end
          if (out_data.cluster_count !== want.cluster_count) begin
            $error("cluster_count: expected %0d, actual %0d",
                   want.cluster_count, out_data.cluster_count);
            mismatch_count++;
          end
        end
      end

      // Register writes; unknown indexes leave everything unchanged.
      if (cfg_we) begin
        case (cfg_index)
          CFG_SECTOR_SIZE: sector_size_reg = cfg_wdata[12:0];
          CFG_MAX_CLUSTER: max_cluster_reg = cfg_wdata[20:0];
          CFG_FAT12_LIMIT: fat12_limit = cfg_wdata;
          CFG_FAT16_LIMIT: fat16_limit = cfg_wdata;
          CFG_FAT32_LIMIT: fat32_limit = cfg_wdata;
          default: ;
        endcase
      end

      // Capture the byte at its offset; bytes past the window are dropped.
      if (in_valid && in_ready) begin
        b = in_data.data_byte;
        if (byte_pos < CAP_LIMIT) begin
          case (byte_pos)
            0:              boot_hdr.jump_bytes[15:8] = b;
            2:              boot_hdr.jump_bytes[7:0] = b;
            11, 12:         boot_hdr.bytes_per_sector[8*(byte_pos-11) +: 8] = b;
            13:             boot_hdr.sectors_per_cluster = b;
            14, 15:         boot_hdr.reserved_sectors[8*(byte_pos-14) +: 8] = b;
            16:             boot_hdr.fat_copies = b;
            17, 18:         boot_hdr.root_entries[8*(byte_pos-17) +: 8] = b;
            19, 20:         boot_hdr.small_total[8*(byte_pos-19) +: 8] = b;
            22, 23:         boot_hdr.small_fat_size[8*(byte_pos-22) +: 8] = b;
            32, 33, 34, 35: boot_hdr.large_total[8*(byte_pos-32) +: 8] = b;
            36, 37, 38, 39: boot_hdr.large_fat_size[8*(byte_pos-36) +: 8] = b;
            510:            boot_hdr.signature_bytes[15:8] = b;
            511:            boot_hdr.signature_bytes[7:0] = b;
            default: ;
          endcase
        end
        // The marked byte closes the sector and starts the next one clean.
        if (in_data.last_byte) begin
          expected_volumes.push_back(classify_volume(boot_hdr));
          boot_hdr = '0;
          byte_pos = '0;
        end else if (byte_pos != POS_MAX) begin
          byte_pos++;
        end
      end
      results_pending = expected_volumes.size();
    end
  end

endmodule

FILE: bench/fat_boot_sector_classifier_test.sv
// Top of the FAT boot sector classifier bench: clock, reset, sector stimulus
// under several register settings, and the verdict.
// Depends on fbsc_pkg, fat_boot_sector_classifier and fat_type_checker.
module fat_boot_sector_classifier_test;
  import fbsc_pkg::*;

  localparam int NUM_SETTINGS        = 7;
  localparam int SECTORS_PER_SETTING = 3;
  localparam int IDLE_LIMIT          = 4000;
  localparam int SETTLE_CYCLES       = 32;
  localparam int FULL_SECTOR_BYTES   = 512;

  typedef enum int {SECT_GOOD, SECT_BROKEN, SECT_NOISE} sector_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int results_pending;
  int results_checked;

  // Register values the sector builder aims at, plus idling knobs.
  logic [12:0] cur_sector_size = RST_SECTOR_SIZE;
  logic [20:0] cur_max_cluster = RST_MAX_CLUSTER;
  int gap_max = 0;
  int stall_max = 0;
  int burst_left = 0;
  int ready_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int sectors_sent = 0;
  logic [7:0] sector_buf[$];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  fat_boot_sector_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fat_type_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .results_checked (results_checked)
  );

  // Receiver: ready runs of random length, broken by stalls of up to stall_max.
  always @(negedge clk) begin
    if (ready_left != 0) begin
      ready_left--;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      ready_left = $urandom_range(1, 24);
      stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      out_ready <= 1'b1;
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("fat_boot_sector_classifier_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One register write, with cfg_we dropped again before the task returns so back-to-back writes never collide.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one byte and hold it until the transfer; bursts are cut by gaps.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: value, last_byte: is_last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic stream_sector();
    int i;
    for (i = 0; i < sector_buf.size(); i++) begin
      send_byte(sector_buf[i], i == sector_buf.size() - 1);
    end
    sectors_sent++;
  endtask

  // Let every result come out and the back end go quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Fill sector_buf with a boot sector: random noise, a well-formed record
  // with random geometry, or a well-formed record with one check broken.
  task automatic build_sector(input sector_kind_t kind);
    int          len;
    int          i;
    logic [15:0] bps;
    logic [15:0] reserved;
    logic [15:0] root_entries;
    logic [15:0] small_total;
    logic [15:0] small_fat;
    logic [31:0] large_total;
    logic [31:0] large_fat;
    logic [7:0]  spc;
    logic [7:0]  copies;
    sector_buf.delete();
    len = (kind == SECT_NOISE) ? $urandom_range(1, 24) : FULL_SECTOR_BYTES;
    for (i = 0; i < len; i++) begin
      sector_buf.push_back(8'($urandom));
    end
    if (kind == SECT_NOISE) return;

    if ($urandom_range(0, 2) == 0) begin
      sector_buf[0] = JMP_NEAR;
    end else begin
      sector_buf[0] = JMP_SHORT;
      sector_buf[2] = JMP_NOP;
    end
    bps = {3'b0, cur_sector_size};
    spc = 8'd1 << $urandom_range(0, 7);
    while (spc > 1 && {16'b0, bps} * spc > {11'b0, cur_max_cluster}) begin
      spc = spc >> 1;
    end
    reserved = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 64));
    copies = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
    root_entries = ($urandom_range(0, 3) == 0) ? 16'd0 :
                   ($urandom_range(0, 1) == 0) ? 16'd512 : 16'($urandom);
    small_fat = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 256));
    large_fat = $urandom >> $urandom_range(8, 31);
    // Totals spread over many magnitudes so every FAT class and wrap shows up.
    small_total = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
    large_total = $urandom >> $urandom_range(0, 31);

    sector_buf[11] = bps[7:0];
    sector_buf[12] = bps[15:8];
    sector_buf[13] = spc;
    sector_buf[14] = reserved[7:0];
    sector_buf[15] = reserved[15:8];
    sector_buf[16] = copies;
    sector_buf[17] = root_entries[7:0];
    sector_buf[18] = root_entries[15:8];
    sector_buf[19] = small_total[7:0];
    sector_buf[20] = small_total[15:8];
    sector_buf[22] = small_fat[7:0];
    sector_buf[23] = small_fat[15:8];
    for (i = 0; i < 4; i++) begin
      sector_buf[32 + i] = large_total[8*i +: 8];
      sector_buf[36 + i] = large_fat[8*i +: 8];
    end
    sector_buf[510] = BOOT_SIG[15:8];
    sector_buf[511] = BOOT_SIG[7:0];

    if (kind == SECT_BROKEN) begin
      case ($urandom_range(0, 5))
        0: begin
          sector_buf[0] = JMP_SHORT;
          sector_buf[2] = JMP_NOP ^ 8'(1 << $urandom_range(0, 7));
        end
        1: sector_buf[11 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        2: sector_buf[13] = ($urandom_range(0, 3) == 0) ? 8'd0
                                                        : 8'(8'd3 << $urandom_range(0, 6));
        3: sector_buf[13] = 8'd128;
        4: begin
          sector_buf[14] = 8'd0;
          sector_buf[15] = 8'd0;
        end
        default: sector_buf[510 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      endcase
    end
  endtask

  // Program one register setting and the idling style that goes with it.
  task automatic apply_setting(input int p);
    logic [12:0] sec;
    logic [20:0] maxc;
    logic [31:0] lim12;
    logic [31:0] lim16;
    logic [31:0] lim32;
    logic [31:0] pad;
    int          i;
    case (p)
      0: begin
        sec = RST_SECTOR_SIZE;
        maxc = RST_MAX_CLUSTER;
        lim12 = RST_FAT12_LIMIT;
        lim16 = RST_FAT16_LIMIT;
        lim32 = RST_FAT32_LIMIT;
      end
      1: begin
        sec = 13'd4096;
        maxc = 21'd1048576;
        lim12 = $urandom_range(0, 100000);
        lim16 = lim12 + $urandom_range(0, 1000000);
        lim32 = lim16 + $urandom_range(0, 300000000);
      end
      2: begin
        // A zero sector size fails every header before any divide.
        sec = 13'd0;
        maxc = 21'd512;
        lim12 = 32'd0;
        lim16 = 32'd0;
        lim32 = 32'd0;
      end
      3: begin
        sec = 13'd512;
        maxc = 21'd512;
        lim12 = 32'hFFFF_FFFF;
        lim16 = 32'hFFFF_FFFF;
        lim32 = 32'hFFFF_FFFF;
      end
      4: begin
        sec = 13'($urandom);
        maxc = 21'($urandom);
        lim12 = $urandom;
        lim16 = $urandom;
        lim32 = $urandom;
      end
      5: begin
        sec = 13'h1FFF;
        maxc = 21'h1F_FFFF;
        lim12 = 32'd0;
        lim16 = 32'hFFFF_FFFF;
        lim32 = 32'd0;
      end
      default: begin
        sec = 13'd1024;
        maxc = 21'd65536;
        lim12 = RST_FAT12_LIMIT;
        lim16 = RST_FAT16_LIMIT;
        lim32 = RST_FAT32_LIMIT;
      end
    endcase
    // One setting carries junk above each narrow register's width.
    pad = (p == 4) ? $urandom : 32'd0;
    write_reg(CFG_SECTOR_SIZE, {pad[31:13], sec});
    write_reg(CFG_MAX_CLUSTER, {pad[31:21], maxc});
    write_reg(CFG_FAT12_LIMIT, lim12);
    write_reg(CFG_FAT16_LIMIT, lim16);
    write_reg(CFG_FAT32_LIMIT, lim32);
    if (p % 3 == 2) begin
      for (i = CFG_FAT32_LIMIT + 1; i < (1 << CFG_IDX_W); i++) begin
        write_reg(CFG_IDX_W'(i), $urandom);
      end
    end
    cur_sector_size = sec;
    cur_max_cluster = maxc;
    gap_max = (p % 3 == 1) ? 0 : $urandom_range(1, 15);
    stall_max = (p % 3 == 2) ? 0 : $urandom_range(1, 12);
  endtask

  initial begin
    int           p;
    int           s;
    sector_kind_t kind;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (p = 0; p < NUM_SETTINGS; p++) begin
      drain_results();
      apply_setting(p);

      // Short sectors: empty-ish headers, both jump forms, a bare sector size.
      if (p == 0) begin
        sector_buf = '{8'h00};
        stream_sector();
        sector_buf = '{8'hFF};
        stream_sector();
        sector_buf = '{JMP_SHORT, 8'h00, JMP_NOP};
        stream_sector();
        sector_buf = '{JMP_NEAR, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h00, 8'hFF,
                       8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h02};
        stream_sector();
      end

      // Full-length records under a few settings keep the run to its byte
      // budget: well-formed ones first, then one with a check broken.
      if (p == 0 || p == 1 || p == NUM_SETTINGS - 1) begin
        kind = (p == NUM_SETTINGS - 1) ? SECT_BROKEN : SECT_GOOD;
        build_sector(kind);
        stream_sector();
      end

      // Short noise sectors around them.
      for (s = 0; s < SECTORS_PER_SETTING; s++) begin
        build_sector(SECT_NOISE);
        stream_sector();
      end
    end

    drain_results();
    $display("Streamed %0d sectors (%0d bytes) under %0d register settings.",
             sectors_sent, bytes_sent, NUM_SETTINGS);
    $display("Checked %0d volume results across short, corrupted and well-formed sectors.",
             results_checked);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("fat_boot_sector_classifier_test OK");
    end else begin
      $display("fat_boot_sector_classifier_test NOT OK");
    end
    $finish;
  end

endmodule
